>>> rtl/ovle_pkg.sv
package ovle_pkg;

	localparam int CAPACITY_DEF = 32;

	typedef enum logic [3:0] {
		CMD_BACK      = 4'd0,
		CMD_FRONT     = 4'd1,
		CMD_AFTER     = 4'd2,
		CMD_BEFORE    = 4'd3,
		CMD_DELETE    = 4'd4,
		CMD_DEL_FRONT = 4'd5,
		CMD_DEL_BACK  = 4'd6,
		CMD_REVERSE   = 4'd7,
		CMD_ROTATE    = 4'd8,
		CMD_SWAP      = 4'd9,
		CMD_PRINT     = 4'd10
	} cmd_t;

	typedef struct packed {
		logic [3:0]         command;
		logic signed [31:0] value;
		logic signed [31:0] reference_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] element_value;
		logic               is_last;
		logic               list_empty;
	} out_item_t;

	// datapath operations issued by the controller
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,       // capture command operands, clear search state
		OP_READ,       // read mem[idx]
		OP_SCAN_CMP,   // compare read data against both keys, advance idx
		OP_SET_BACK,   // insert slot at count
		OP_SET_FRONT,  // insert slot at zero
		OP_SET_AFTER,  // insert slot after reference match
		OP_SET_BEFORE, // insert slot at reference match
		OP_UP_RD,      // read mem[idx-1] to open a gap
		OP_UP_WR,      // write it to mem[idx], step idx down
		OP_PUT,        // write insert value, bump count
		OP_SET_DPOS,   // start closing the gap at the value match
		OP_DN_RD,      // read mem[idx+1] to close a gap
		OP_DN_WR,      // write it to mem[idx], step idx up
		OP_DEC,        // drop the last element
		OP_REV_WHOLE,  // reversal range [0, count)
		OP_REV_HEAD,   // reversal range [0, rem)
		OP_REV_TAIL,   // reversal range [rem, count)
		OP_REV_RDA,    // read lo
		OP_REV_RDB,    // read hi-1, hold lo
		OP_REV_WRA,    // write lo from hi-1
		OP_REV_WRB,    // write hi-1 from lo, narrow range
		OP_MOD,        // one bit of amount mod count
		OP_SWAP_WRA,   // write value at reference position
		OP_SWAP_WRB,   // write reference at value position
		OP_NEXT        // advance print index
	} op_t;

	typedef struct packed {
		logic scan_done;  // index reached count
		logic hit_a;      // match for value found
		logic hit_b;      // match for reference found
		logic full;
		logic empty;
		logic ins_done;   // gap reached insert slot
		logic del_done;   // gap reached the end
		logic rev_done;   // reversal range exhausted
		logic mod_last;   // final remainder step
		logic mod_zero;   // remainder is zero
		logic rot_ok;     // amount positive
		logic pr_last;    // print index on last element
	} stat_t;

endpackage

>>> rtl/ovle_datapath.sv
module ovle_datapath #(
	parameter int CAPACITY = ovle_pkg::CAPACITY_DEF,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ovle_pkg::in_item_t  item,
	input  ovle_pkg::op_t       ctrl,
	output ovle_pkg::stat_t     stat,
	output ovle_pkg::out_item_t res
);

	logic [31:0]   mem [CAPACITY];
	logic [31:0]   rd_q, hold_q;
	logic [31:0]   val_q, ref_q;
	logic [CW-1:0] count_q, idx_q, ins_q, pos_q, posb_q, lo_q, hi_q, rem_q;
	logic [4:0]    bit_q;
	logic          hit_a_q, hit_b_q;
	logic [CW-1:0] idx_dn, idx_up, hi_dn;
	logic [CW:0]   idx_up_x, lo_up_x, mod_sh, mod_nx;
	logic          mod_ge;

	assign idx_dn   = idx_q - CW'(1);
	assign idx_up   = idx_q + CW'(1);
	assign hi_dn    = hi_q - CW'(1);
	assign idx_up_x = {1'b0, idx_q} + (CW+1)'(1);
	assign lo_up_x  = {1'b0, lo_q} + (CW+1)'(1);

	// restoring remainder: one amount bit per cycle, msb first
	assign mod_sh = {rem_q, val_q[bit_q]};
	assign mod_ge = mod_sh >= {1'b0, count_q};
	assign mod_nx = mod_ge ? mod_sh - {1'b0, count_q} : mod_sh;

	// operands, indexes and read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			ins_q   <= '0;
			pos_q   <= '0;
			posb_q  <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			rem_q   <= '0;
			bit_q   <= '0;
			hit_a_q <= 1'b0;
			hit_b_q <= 1'b0;
			val_q   <= '0;
			ref_q   <= '0;
			rd_q    <= '0;
			hold_q  <= '0;
		end else begin
			unique case (ctrl)
				ovle_pkg::OP_LOAD: begin
					val_q   <= item.value;
					ref_q   <= item.reference_value;
					idx_q   <= '0;
					hit_a_q <= 1'b0;
					hit_b_q <= 1'b0;
					rem_q   <= '0;
					bit_q   <= 5'd31;
				end
				ovle_pkg::OP_READ: rd_q <= mem[idx_q[AW-1:0]];
				ovle_pkg::OP_SCAN_CMP: begin
					// keep the first match for each key
					if (!hit_a_q && rd_q == val_q) begin
						hit_a_q <= 1'b1;
						pos_q   <= idx_q;
					end
					if (!hit_b_q && rd_q == ref_q) begin
						hit_b_q <= 1'b1;
						posb_q  <= idx_q;
					end
					idx_q <= idx_up;
				end
				ovle_pkg::OP_SET_BACK: begin
					ins_q <= count_q;
					idx_q <= count_q;
				end
				ovle_pkg::OP_SET_FRONT: begin
					ins_q <= '0;
					idx_q <= count_q;
				end
				ovle_pkg::OP_SET_AFTER: begin
					ins_q <= posb_q + CW'(1);
					idx_q <= count_q;
				end
				ovle_pkg::OP_SET_BEFORE: begin
					ins_q <= posb_q;
					idx_q <= count_q;
				end
				ovle_pkg::OP_UP_RD: rd_q <= mem[idx_dn[AW-1:0]];
				ovle_pkg::OP_UP_WR: idx_q <= idx_dn;
				ovle_pkg::OP_PUT: count_q <= count_q + CW'(1);
				ovle_pkg::OP_SET_DPOS: idx_q <= pos_q;
				ovle_pkg::OP_DN_RD: rd_q <= mem[idx_up[AW-1:0]];
				ovle_pkg::OP_DN_WR: idx_q <= idx_up;
				ovle_pkg::OP_DEC: count_q <= count_q - CW'(1);
				ovle_pkg::OP_REV_WHOLE: begin
					lo_q <= '0;
					hi_q <= count_q;
				end
				ovle_pkg::OP_REV_HEAD: begin
					lo_q <= '0;
					hi_q <= rem_q;
				end
				ovle_pkg::OP_REV_TAIL: begin
					lo_q <= rem_q;
					hi_q <= count_q;
				end
				ovle_pkg::OP_REV_RDA: rd_q <= mem[lo_q[AW-1:0]];
				ovle_pkg::OP_REV_RDB: begin
					hold_q <= rd_q;
					rd_q   <= mem[hi_dn[AW-1:0]];
				end
				ovle_pkg::OP_REV_WRB: begin
					lo_q <= lo_q + CW'(1);
					hi_q <= hi_dn;
				end
				ovle_pkg::OP_MOD: begin
					rem_q <= mod_nx[CW-1:0];
					bit_q <= bit_q - 5'd1;
				end
				ovle_pkg::OP_NEXT: idx_q <= idx_up;
				default: ;
			endcase
		end
	end

	// element storage, one write per cycle
	always_ff @(posedge clk) begin
		unique case (ctrl)
			ovle_pkg::OP_UP_WR:    mem[idx_q[AW-1:0]]  <= rd_q;
			ovle_pkg::OP_PUT:      mem[ins_q[AW-1:0]]  <= val_q;
			ovle_pkg::OP_DN_WR:    mem[idx_q[AW-1:0]]  <= rd_q;
			ovle_pkg::OP_REV_WRA:  mem[lo_q[AW-1:0]]   <= rd_q;
			ovle_pkg::OP_REV_WRB:  mem[hi_dn[AW-1:0]]  <= hold_q;
			ovle_pkg::OP_SWAP_WRA: mem[posb_q[AW-1:0]] <= val_q;
			ovle_pkg::OP_SWAP_WRB: mem[pos_q[AW-1:0]]  <= ref_q;
			default: ;
		endcase
	end

	// status to the controller and print result
	always_comb begin
		stat.scan_done   = idx_q == count_q;
		stat.hit_a       = hit_a_q;
		stat.hit_b       = hit_b_q;
		stat.full        = count_q == CW'(CAPACITY);
		stat.empty       = count_q == '0;
		stat.ins_done    = idx_q == ins_q;
		stat.del_done    = idx_up_x >= {1'b0, count_q};
		stat.rev_done    = lo_up_x >= {1'b0, hi_q};
		stat.mod_last    = bit_q == '0;
		stat.mod_zero    = rem_q == '0;
		stat.rot_ok      = !val_q[31] && val_q != '0;
		stat.pr_last     = idx_up_x == {1'b0, count_q};
		res.element_value = (count_q == '0) ? '0 : rd_q;
		res.is_last       = count_q == '0 || idx_up_x == {1'b0, count_q};
		res.list_empty    = count_q == '0;
	end

endmodule

>>> rtl/ovle_ctrl.sv
module ovle_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ovle_pkg::in_item_t item,
	output logic               out_valid,
	input  logic               out_ready,
	input  ovle_pkg::stat_t    stat,
	output ovle_pkg::op_t      ctrl
);

	typedef enum logic [17:0] {
		S_IDLE   = 18'b000000000000000001,
		S_DISP   = 18'b000000000000000010,
		S_SCHK   = 18'b000000000000000100,
		S_SCMP   = 18'b000000000000001000,
		S_FOUND  = 18'b000000000000010000,
		S_INS    = 18'b000000000000100000,
		S_UPWR   = 18'b000000000001000000,
		S_DEL    = 18'b000000000010000000,
		S_DNWR   = 18'b000000000100000000,
		S_SWAPB  = 18'b000000001000000000,
		S_MOD    = 18'b000000010000000000,
		S_MODCHK = 18'b000000100000000000,
		S_REV    = 18'b000001000000000000,
		S_RB     = 18'b000010000000000000,
		S_RWA    = 18'b000100000000000000,
		S_RWB    = 18'b001000000000000000,
		S_PRRD   = 18'b010000000000000000,
		S_PROUT  = 18'b100000000000000000
	} state_t;

	// which of the three rotate reversals is running
	typedef enum logic [1:0] {
		STG_WHOLE = 2'd0,
		STG_HEAD  = 2'd1,
		STG_TAIL  = 2'd2
	} stage_t;

	state_t             state_q, state_d;
	ovle_pkg::cmd_t     cmd_q;
	stage_t             stage_q;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = state_q == S_PROUT;

	// sequence datapath operations
	always_comb begin
		state_d = state_q;
		ctrl    = ovle_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				ctrl    = ovle_pkg::OP_LOAD;
				state_d = S_DISP;
			end
			S_DISP: begin
				state_d = S_IDLE;
				unique case (cmd_q)
					ovle_pkg::CMD_BACK: if (!stat.full) begin
						ctrl    = ovle_pkg::OP_SET_BACK;
						state_d = S_INS;
					end
					ovle_pkg::CMD_FRONT: if (!stat.full) begin
						ctrl    = ovle_pkg::OP_SET_FRONT;
						state_d = S_INS;
					end
					ovle_pkg::CMD_AFTER, ovle_pkg::CMD_BEFORE,
					ovle_pkg::CMD_DELETE, ovle_pkg::CMD_SWAP: state_d = S_SCHK;
					ovle_pkg::CMD_DEL_FRONT: if (!stat.empty) state_d = S_DEL;
					ovle_pkg::CMD_DEL_BACK: if (!stat.empty) ctrl = ovle_pkg::OP_DEC;
					ovle_pkg::CMD_REVERSE: if (!stat.empty) begin
						ctrl    = ovle_pkg::OP_REV_WHOLE;
						state_d = S_REV;
					end
					ovle_pkg::CMD_ROTATE: if (!stat.empty && stat.rot_ok) state_d = S_MOD;
					ovle_pkg::CMD_PRINT: state_d = stat.empty ? S_PROUT : S_PRRD;
					default: ;
				endcase
			end
			// walk the whole list looking for both keys
			S_SCHK: begin
				if (stat.scan_done) begin
					state_d = S_FOUND;
				end else begin
					ctrl    = ovle_pkg::OP_READ;
					state_d = S_SCMP;
				end
			end
			S_SCMP: begin
				ctrl    = ovle_pkg::OP_SCAN_CMP;
				state_d = S_SCHK;
			end
			S_FOUND: begin
				state_d = S_IDLE;
				unique case (cmd_q)
					ovle_pkg::CMD_AFTER: if (stat.hit_b && !stat.full) begin
						ctrl    = ovle_pkg::OP_SET_AFTER;
						state_d = S_INS;
					end
					ovle_pkg::CMD_BEFORE: if (stat.hit_b && !stat.full) begin
						ctrl    = ovle_pkg::OP_SET_BEFORE;
						state_d = S_INS;
					end
					ovle_pkg::CMD_DELETE: if (stat.hit_a) begin
						ctrl    = ovle_pkg::OP_SET_DPOS;
						state_d = S_DEL;
					end
					ovle_pkg::CMD_SWAP: if (stat.hit_a && stat.hit_b) begin
						ctrl    = ovle_pkg::OP_SWAP_WRA;
						state_d = S_SWAPB;
					end
					default: ;
				endcase
			end
			// open a gap from the top down, then drop the value in
			S_INS: begin
				if (stat.ins_done) begin
					ctrl    = ovle_pkg::OP_PUT;
					state_d = S_IDLE;
				end else begin
					ctrl    = ovle_pkg::OP_UP_RD;
					state_d = S_UPWR;
				end
			end
			S_UPWR: begin
				ctrl    = ovle_pkg::OP_UP_WR;
				state_d = S_INS;
			end
			// close the gap toward the end, then drop the last slot
			S_DEL: begin
				if (stat.del_done) begin
					ctrl    = ovle_pkg::OP_DEC;
					state_d = S_IDLE;
				end else begin
					ctrl    = ovle_pkg::OP_DN_RD;
					state_d = S_DNWR;
				end
			end
			S_DNWR: begin
				ctrl    = ovle_pkg::OP_DN_WR;
				state_d = S_DEL;
			end
			S_SWAPB: begin
				ctrl    = ovle_pkg::OP_SWAP_WRB;
				state_d = S_IDLE;
			end
			S_MOD: begin
				ctrl = ovle_pkg::OP_MOD;
				if (stat.mod_last) state_d = S_MODCHK;
			end
			S_MODCHK: begin
				if (stat.mod_zero) begin
					state_d = S_IDLE;
				end else begin
					ctrl    = ovle_pkg::OP_REV_WHOLE;
					state_d = S_REV;
				end
			end
			// swap ends of the range; rotate chains head and tail ranges
			S_REV: begin
				if (!stat.rev_done) begin
					ctrl    = ovle_pkg::OP_REV_RDA;
					state_d = S_RB;
				end else if (cmd_q == ovle_pkg::CMD_ROTATE && stage_q == STG_WHOLE) begin
					ctrl = ovle_pkg::OP_REV_HEAD;
				end else if (cmd_q == ovle_pkg::CMD_ROTATE && stage_q == STG_HEAD) begin
					ctrl = ovle_pkg::OP_REV_TAIL;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_RB: begin
				ctrl    = ovle_pkg::OP_REV_RDB;
				state_d = S_RWA;
			end
			S_RWA: begin
				ctrl    = ovle_pkg::OP_REV_WRA;
				state_d = S_RWB;
			end
			S_RWB: begin
				ctrl    = ovle_pkg::OP_REV_WRB;
				state_d = S_REV;
			end
			S_PRRD: begin
				ctrl    = ovle_pkg::OP_READ;
				state_d = S_PROUT;
			end
			// hold the result until the transfer
			S_PROUT: if (out_ready) begin
				ctrl    = ovle_pkg::OP_NEXT;
				state_d = (stat.empty || stat.pr_last) ? S_IDLE : S_PRRD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= ovle_pkg::CMD_BACK;
			stage_q <= STG_WHOLE;
		end else begin
			state_q <= state_d;
			if (ctrl == ovle_pkg::OP_LOAD) cmd_q <= ovle_pkg::cmd_t'(item.command);
			if (ctrl == ovle_pkg::OP_REV_WHOLE)     stage_q <= STG_WHOLE;
			else if (ctrl == ovle_pkg::OP_REV_HEAD) stage_q <= STG_HEAD;
			else if (ctrl == ovle_pkg::OP_REV_TAIL) stage_q <= STG_TAIL;
		end
	end

endmodule

>>> rtl/ordered_value_list_engine_top.sv
// Ordered list of up to CAPACITY signed 32-bit values held in an internal
// memory, driven by one command per input transfer. Only print returns
// results: one per element in list order with is_last on the final one,
// or one marker with list_empty set when the list is empty. Commands run
// one at a time and in_ready stays low until the current one is done.
// Append and delete back move no other element; prepend, reverse and
// delete front step through the whole list, a search walks the whole
// list before any shift, and rotate runs a bitwise remainder step and
// then, unless the remainder is zero, three in-place reversals through
// the single memory port. Print reads each element and holds it until
// the output transfer, so output stalls hold it up.
module ordered_value_list_engine_top #(
	parameter int CAPACITY = ovle_pkg::CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ovle_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ovle_pkg::out_item_t out_data
);

	ovle_pkg::op_t   ctrl;
	ovle_pkg::stat_t stat;

	ovle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item     (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	ovle_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (in_data),
		.ctrl  (ctrl),
		.stat  (stat),
		.res   (out_data)
	);

endmodule

>>> tb/ovle_checker.sv
module ovle_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  ovle_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  ovle_pkg::out_item_t out_data,
	output int                  fails,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = ovle_pkg::CAPACITY_DEF;

	logic signed [31:0]  shadow_list[$];
	ovle_pkg::out_item_t print_queue[$];
	int                  fail_cnt = 0;

	assign fails   = fail_cnt;
	assign pending = print_queue.size();

	function automatic int find_first(logic signed [31:0] v);
		int i;
		for (i = 0; i < shadow_list.size(); i++)
			if (shadow_list[i] == v)
				return i;
		return -1;
	endfunction

	// apply one command to the shadow list, queue any print output
	task automatic apply_command(ovle_pkg::in_item_t item);
		int                  p;
		int                  q;
		int                  r;
		ovle_pkg::out_item_t o;
		case (item.command)
			ovle_pkg::CMD_BACK: begin
				if (shadow_list.size() < DEPTH)
					shadow_list.push_back(item.value);
			end
			ovle_pkg::CMD_FRONT: begin
				if (shadow_list.size() < DEPTH)
					shadow_list.push_front(item.value);
			end
			ovle_pkg::CMD_AFTER, ovle_pkg::CMD_BEFORE: begin
				p = find_first(item.reference_value);
				if (p >= 0 && shadow_list.size() < DEPTH)
					shadow_list.insert(item.command == ovle_pkg::CMD_AFTER ? p + 1 : p,
						item.value);
			end
			ovle_pkg::CMD_DELETE: begin
				p = find_first(item.value);
				if (p >= 0)
					shadow_list.delete(p);
			end
			ovle_pkg::CMD_DEL_FRONT: begin
				if (shadow_list.size() > 0)
					void'(shadow_list.pop_front());
			end
			ovle_pkg::CMD_DEL_BACK: begin
				if (shadow_list.size() > 0)
					void'(shadow_list.pop_back());
			end
			ovle_pkg::CMD_REVERSE: begin
				shadow_list.reverse();
			end
			ovle_pkg::CMD_ROTATE: begin
				if (shadow_list.size() > 0 && item.value > 0) begin
					r = item.value % shadow_list.size();
					repeat (r) shadow_list.push_front(shadow_list.pop_back());
				end
			end
			ovle_pkg::CMD_SWAP: begin
				p = find_first(item.value);
				q = find_first(item.reference_value);
				if (p >= 0 && q >= 0) begin
					shadow_list[q] = item.value;
					shadow_list[p] = item.reference_value;
				end
			end
			ovle_pkg::CMD_PRINT: begin
				if (shadow_list.size() == 0) begin
					o.element_value = '0;
					o.is_last       = 1'b1;
					o.list_empty    = 1'b1;
					print_queue.push_back(o);
				end else begin
					for (p = 0; p < shadow_list.size(); p++) begin
						o.element_value = shadow_list[p];
						o.is_last       = (p == shadow_list.size() - 1);
						o.list_empty    = 1'b0;
						print_queue.push_back(o);
					end
				end
			end
			default: ;
		endcase
	endtask

	// predict on input transfers, compare on output transfers
	always @(posedge clk) begin
		ovle_pkg::out_item_t e;
		if (arst_n) begin
			if (in_valid && in_ready)
				apply_command(in_data);
			if (out_valid && out_ready) begin
				if (print_queue.size() == 0) begin
					$error("unexpected result: element_value %0d", out_data.element_value);
					fail_cnt++;
				end else begin
					e = print_queue.pop_front();
					if (out_data.element_value !== e.element_value) begin
						$error("element_value: expected %0d, got %0d",
							e.element_value, out_data.element_value);
						fail_cnt++;
					end
					if (out_data.is_last !== e.is_last) begin
						$error("is_last: expected %0b, got %0b", e.is_last, out_data.is_last);
						fail_cnt++;
					end
					if (out_data.list_empty !== e.list_empty) begin
						$error("list_empty: expected %0b, got %0b",
							e.list_empty, out_data.list_empty);
						fail_cnt++;
					end
				end
			end
		end
	end
endmodule

>>> tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int N_RANDOM    = 360;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	ovle_pkg::in_item_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	ovle_pkg::out_item_t out_data;
	int                  fails;
	int                  pending;
	int                  idle_pct = 0;
	int                  stall_pct = 0;
	int                  cycles = 0;

	ordered_value_list_engine_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	ovle_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fails(fails), .pending(pending)
	);

	always #10 clk = ~clk;

	// stall the receiver at random, abort on timeout
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// hold valid and payload until the transfer happens
	task automatic send(logic [3:0] cmd, logic signed [31:0] v, logic signed [31:0] r);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{command: cmd, value: v, reference_value: r};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// mostly small values so searches hit, sometimes full-range ones
	function automatic logic signed [31:0] pick_value();
		if ($urandom_range(3) == 0)
			return $urandom;
		return $signed($urandom_range(15)) - 8;
	endfunction

	function automatic logic signed [31:0] pick_amount();
		case ($urandom_range(4))
			0: return 0;
			1: return -$signed(32'($urandom_range(1, 41)));
			2: return $urandom;
			default: return $urandom_range(1, 40);
		endcase
	endfunction

	task automatic random_item();
		logic [3:0] cmd;
		int         k;
		k = $urandom_range(99);
		if (k < 14)      cmd = ovle_pkg::CMD_PRINT;
		else if (k < 26) cmd = ovle_pkg::CMD_BACK;
		else if (k < 34) cmd = ovle_pkg::CMD_FRONT;
		else if (k < 44) cmd = ovle_pkg::CMD_AFTER;
		else if (k < 54) cmd = ovle_pkg::CMD_BEFORE;
		else if (k < 62) cmd = ovle_pkg::CMD_DELETE;
		else if (k < 67) cmd = ovle_pkg::CMD_DEL_FRONT;
		else if (k < 72) cmd = ovle_pkg::CMD_DEL_BACK;
		else if (k < 77) cmd = ovle_pkg::CMD_REVERSE;
		else if (k < 85) cmd = ovle_pkg::CMD_ROTATE;
		else if (k < 95) cmd = ovle_pkg::CMD_SWAP;
		else             cmd = 4'($urandom_range(11, 15));
		if (cmd == ovle_pkg::CMD_ROTATE)
			send(cmd, pick_amount(), $urandom);
		else
			send(cmd, pick_value(), pick_value());
	endtask

	initial begin
		int i;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, extremes, each command and corner
		send(ovle_pkg::CMD_PRINT, 0, 0);
		send(ovle_pkg::CMD_DEL_FRONT, 0, 0);
		send(ovle_pkg::CMD_DEL_BACK, 0, 0);
		send(ovle_pkg::CMD_REVERSE, 0, 0);
		send(ovle_pkg::CMD_ROTATE, 3, 0);
		send(ovle_pkg::CMD_SWAP, 1, 2);
		send(ovle_pkg::CMD_DELETE, 1, 0);
		send(ovle_pkg::CMD_BACK, 32'sh7fffffff, 32'sh80000000);
		send(ovle_pkg::CMD_FRONT, 32'sh80000000, 32'sh7fffffff);
		send(ovle_pkg::CMD_AFTER, 5, 32'sh80000000);
		send(ovle_pkg::CMD_AFTER, 6, 99);
		send(ovle_pkg::CMD_BEFORE, 7, 32'sh7fffffff);
		send(ovle_pkg::CMD_BEFORE, 8, 99);
		send(ovle_pkg::CMD_PRINT, 0, 0);
		send(ovle_pkg::CMD_ROTATE, 0, 0);
		send(ovle_pkg::CMD_ROTATE, -1, 0);
		send(ovle_pkg::CMD_ROTATE, 5, 0);
		send(ovle_pkg::CMD_REVERSE, 0, 0);
		send(ovle_pkg::CMD_SWAP, 5, 5);
		send(ovle_pkg::CMD_SWAP, 5, 7);
		send(ovle_pkg::CMD_PRINT, 0, 0);
		send(ovle_pkg::CMD_DELETE, 7, 0);
		send(ovle_pkg::CMD_DEL_FRONT, 0, 0);
		send(ovle_pkg::CMD_DEL_BACK, 0, 0);
		send(4'd15, -1, -1);
		send(ovle_pkg::CMD_PRINT, 0, 0);

		// run the list into its full state, then try inserts there
		repeat (36) send($urandom_range(1) ? ovle_pkg::CMD_BACK : ovle_pkg::CMD_FRONT,
			pick_value(), 0);
		send(ovle_pkg::CMD_AFTER, 3, -8);
		send(ovle_pkg::CMD_BEFORE, 4, 0);

		// random: four idling phases
		for (i = 0; i < N_RANDOM; i++) begin
			case (i / (N_RANDOM / 4))
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 84; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 84; end
				default: begin idle_pct = 32; stall_pct = 32; end
			endcase
			if (i == N_RANDOM / 2) begin
				// pause until the engine has drained
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			random_item();
		end
		in_valid <= 1'b0;
		stall_pct = 0;

		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

>>> filelist.f
rtl/ovle_pkg.sv
rtl/ovle_datapath.sv
rtl/ovle_ctrl.sv
rtl/ordered_value_list_engine_top.sv
tb/ovle_checker.sv
tb/tb.sv
